// File: design/abc_pkg.sv
// Shared codes, reset values and sizes for the affine byte cipher.
`default_nettype none

package abc_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_INDEX_W = 3;

    // Operating modes
    typedef enum logic [1:0] {
        MODE_CBC_ENC = 2'd0,
        MODE_CBC_DEC = 2'd1,
        MODE_CTR     = 2'd2,
        MODE_PASS    = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_MULT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ADD     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_VECTOR = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CTR_NONCE   = 3'd4;

    // Reset values
    localparam mode_t            MODE_RESET        = MODE_CBC_ENC;
    localparam logic [BYTE_W-1:0] KEY_MULT_RESET    = 8'd5;
    localparam logic [BYTE_W-1:0] KEY_ADD_RESET     = 8'd77;
    localparam logic [BYTE_W-1:0] INIT_VECTOR_RESET = 8'd170;
    localparam logic [BYTE_W-1:0] CTR_NONCE_RESET   = 8'd0;
    localparam logic [BYTE_W-1:0] INVERSE_RESET     = 8'd205;

    // Three Newton passes, two multiplies each, one multiply per cycle
    localparam int NEWTON_STEPS = 6;
    localparam int STEP_W = $clog2(NEWTON_STEPS);

endpackage : abc_pkg

`default_nettype wire

// File: design/abc_inv.sv
// Multi-cycle inverse of the key multiplier modulo 256 by Newton iteration.
`default_nettype none

module abc_inv
    import abc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [BYTE_W-1:0] mult,
    output logic                   busy,
    output logic      [BYTE_W-1:0] inverse
);

    logic [BYTE_W-1:0]   a_reg;
    logic [BYTE_W-1:0]   x_reg;
    logic [BYTE_W-1:0]   t_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                busy_reg;
    logic [BYTE_W-1:0]   inv_reg;

    logic [BYTE_W-1:0]   op_l;
    logic [BYTE_W-1:0]   op_r;
    logic [2*BYTE_W-1:0] prod_full;
    logic [BYTE_W-1:0]   prod;
    logic                last_step;

    // Even steps form a*x, odd steps form x*(2 - a*x)
    always_comb
    begin
        if (step_reg[0] == 1'b0)
        begin
            op_l = a_reg;
            op_r = x_reg;
        end
        else
        begin
            op_l = x_reg;
            op_r = BYTE_W'(2) - t_reg;
        end
    end

    assign prod_full = op_l * op_r;
    assign prod      = prod_full[BYTE_W-1:0];
    assign last_step = (step_reg == STEP_W'(NEWTON_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            inv_reg  <= INVERSE_RESET;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (last_step)
            begin
                busy_reg <= 1'b0;
                // an even multiplier has no inverse: use zero
                inv_reg  <= a_reg[0] ? prod : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= mult;
            x_reg <= mult;
        end
        else if (busy_reg)
        begin
            if (step_reg[0] == 1'b0)
            begin
                t_reg <= prod;
            end
            else
            begin
                x_reg <= prod;
            end
        end
    end

    assign busy    = busy_reg;
    assign inverse = inv_reg;

endmodule : abc_inv

`default_nettype wire

// File: design/affine_byte_cipher_cbc_ctr.sv
// Affine byte cipher top level: CBC encrypt, CBC decrypt and CTR over a byte stream.
`default_nettype none

// One byte is accepted per clock cycle while in_ready is high. The beat is held
// in an input register, then the cipher (one 8x8 multiply with an add and XOR
// either side) and the chaining or counter update complete combinationally into
// the result register, which a stalled consumer may hold while the next beat
// waits in the input register. A write to key_mult starts a computation of its
// inverse modulo 256 on a separate 8-bit multiplier; in_ready stays low while
// it is busy. An even key_mult gives an inverse of zero. Mode 3 passes data
// through unchanged.

module affine_byte_cipher_cbc_ctr
    import abc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]      cfg_data,
    // input channel
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [BYTE_W-1:0]      data_in,
    input  wire logic                   start_of_message,
    // output channel
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [BYTE_W-1:0]      data_out
);

    // configuration registers
    mode_t             mode_reg;
    logic [BYTE_W-1:0] key_mult_reg;
    logic [BYTE_W-1:0] key_add_reg;
    logic [BYTE_W-1:0] init_vector_reg;
    logic [BYTE_W-1:0] ctr_nonce_reg;

    // cipher state
    logic [BYTE_W-1:0] chain_reg;
    logic [BYTE_W-1:0] idx_reg;

    // input and result registers
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_data_reg;
    logic              s1_start_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;

    logic                inv_start;
    logic                inv_busy;
    logic [BYTE_W-1:0]   mult_inverse;

    logic                out_free;
    logic                s1_fire;
    logic                in_fire;

    logic [BYTE_W-1:0]   chain_eff;
    logic [BYTE_W-1:0]   idx_eff;
    logic [BYTE_W-1:0]   mul_a;
    logic [BYTE_W-1:0]   mul_x;
    logic [2*BYTE_W-1:0] prod_full;
    logic [BYTE_W-1:0]   prod;
    logic [BYTE_W-1:0]   affine;
    logic [BYTE_W-1:0]   result;
    logic [BYTE_W-1:0]   chain_next;
    logic [BYTE_W-1:0]   idx_next;

    assign inv_start = cfg_we && (cfg_index == REG_KEY_MULT);

    abc_inv u_inv (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (inv_start),
        .mult    (cfg_data),
        .busy    (inv_busy),
        .inverse (mult_inverse)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_RESET;
            key_mult_reg    <= KEY_MULT_RESET;
            key_add_reg     <= KEY_ADD_RESET;
            init_vector_reg <= INIT_VECTOR_RESET;
            ctr_nonce_reg   <= CTR_NONCE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:        mode_reg        <= mode_t'(cfg_data[1:0]);
                REG_KEY_MULT:    key_mult_reg    <= cfg_data;
                REG_KEY_ADD:     key_add_reg     <= cfg_data;
                REG_INIT_VECTOR: init_vector_reg <= cfg_data;
                REG_CTR_NONCE:   ctr_nonce_reg   <= cfg_data;
                default:         ;  // drop writes to unknown indexes
            endcase
        end
    end

    // handshake
    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = (!s1_valid_reg || out_free) && !inv_busy;
    assign in_fire  = in_valid && in_ready;

    // a start beat restarts chaining from the IV and the counter from zero
    assign chain_eff = s1_start_reg ? init_vector_reg : chain_reg;
    assign idx_eff   = s1_start_reg ? '0 : idx_reg;

    always_comb
    begin
        mul_a = key_mult_reg;
        mul_x = s1_data_reg ^ chain_eff;
        unique case (mode_reg)
            MODE_CBC_ENC: mul_x = s1_data_reg ^ chain_eff;
            MODE_CBC_DEC:
            begin
                mul_a = mult_inverse;
                mul_x = s1_data_reg - key_add_reg;
            end
            MODE_CTR:     mul_x = ctr_nonce_reg + idx_eff;
            MODE_PASS:    mul_x = s1_data_reg;
            default:      mul_x = s1_data_reg;
        endcase
    end

    assign prod_full = mul_a * mul_x;
    assign prod      = prod_full[BYTE_W-1:0];
    assign affine    = prod + key_add_reg;

    always_comb
    begin
        result     = s1_data_reg;
        chain_next = chain_eff;
        idx_next   = idx_eff;
        unique case (mode_reg)
            MODE_CBC_ENC:
            begin
                result     = affine;
                chain_next = affine;
            end
            MODE_CBC_DEC:
            begin
                result     = prod ^ chain_eff;
                chain_next = s1_data_reg;
            end
            MODE_CTR:
            begin
                result   = s1_data_reg ^ affine;
                idx_next = idx_eff + BYTE_W'(1);
            end
            MODE_PASS:    result = s1_data_reg;
            default:      result = s1_data_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                chain_reg     <= chain_next;
                idx_reg       <= idx_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg  <= data_in;
            s1_start_reg <= start_of_message;
        end
        if (s1_fire)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;

    // a key_mult write blocks input until its inverse is ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == REG_KEY_MULT)) |=> !in_ready)
    else $error("input taken while the multiplier inverse is being computed");

    // once settled, the inverse matches the multiplier
    assert property (@(posedge clk) disable iff (!rst_n)
        !inv_busy |-> (key_mult_reg[0] ? (8'(key_mult_reg * mult_inverse) == 8'd1)
                                       : (mult_inverse == '0)))
    else $error("multiplier inverse does not match key_mult");

    // CBC encrypt chains on the ciphertext it just produced
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (mode_reg == MODE_CBC_ENC)) |=> (chain_reg == data_out))
    else $error("CBC encrypt chaining byte differs from the ciphertext");

    // a CTR start beat leaves the counter at one
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_start_reg && (mode_reg == MODE_CTR)) |=> (idx_reg == 8'd1))
    else $error("CTR counter not restarted on a start beat");

endmodule : affine_byte_cipher_cbc_ctr

`default_nettype wire
